/* rtl/core/assert_macros.svh */
// Assertion macros shared by the RTL of the Playfair cipher block.
// Each macro expects signals named clk and rst in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define CHK_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error(msg);

// Check that a trigger implies a consequence in the same cycle.
`define CHK_IMPLY(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) \
    else $error(msg);

`endif

/* rtl/core/plf_pkg.sv */
// Shared constants, types and helper functions of the Playfair cipher block.
// No dependencies; imported by every module under rtl/core.
package plf_pkg;

  localparam int unsigned SIDE    = 5;
  localparam int unsigned CELLS   = 25;
  localparam int unsigned LETTERS = 26;

  localparam logic [4:0] CODE_Q        = 5'd16;
  localparam logic [4:0] CODE_X        = 5'd23;
  localparam logic [4:0] CODE_Z        = 5'd25;
  localparam logic [4:0] LAST_LETTER   = 5'd25;
  localparam logic [4:0] CELL_COUNT    = 5'd25;
  localparam logic [4:0] IGNORED_RESET = 5'd9;

  localparam logic [2:0] COORD_LAST = 3'd4;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_KEY   = 2'd1;
  localparam logic [1:0] CMD_XFORM = 2'd2;

  localparam logic CFG_IGNORED = 1'b0;
  localparam logic CFG_DECRYPT = 1'b1;

  typedef logic [4:0] letter_t;
  typedef logic [4:0] cell_t;
  typedef logic [2:0] coord_t;

  // Write into the key square and position table.
  typedef struct packed {
    logic    en;
    cell_t   slot;
    letter_t letter;
  } key_wr_t;

  // Request state carried from the lookup stage to the square stage.
  typedef struct packed {
    logic        xform;
    logic        absent;
    letter_t     ra;
    letter_t     rb;
    logic [7:0]  tag;
    logic        sticky;
    logic [4:0]  fill;
    logic        decrypt;
  } item_t;

  typedef struct packed {
    coord_t row;
    coord_t col;
  } rc_t;

  function automatic rc_t split_pos(cell_t pos);
    rc_t   r;
    cell_t base;
    cell_t diff;
    if (pos >= 5'd20) begin
      r.row = 3'd4;
    end else if (pos >= 5'd15) begin
      r.row = 3'd3;
    end else if (pos >= 5'd10) begin
      r.row = 3'd2;
    end else if (pos >= 5'd5) begin
      r.row = 3'd1;
    end else begin
      r.row = 3'd0;
    end
    base  = {r.row, 2'b00} + {2'b00, r.row};
    diff  = pos - base;
    r.col = diff[2:0];
    return r;
  endfunction

  // Move one place along a row or column, wrapping at the edge.
  function automatic coord_t step_coord(coord_t c, logic back);
    coord_t n;
    if (back) begin
      n = (c == 3'd0) ? COORD_LAST : c - 3'd1;
    end else begin
      n = (c == COORD_LAST) ? 3'd0 : c + 3'd1;
    end
    return n;
  endfunction

  function automatic cell_t cell_index(coord_t row, coord_t col);
    return {row, 2'b00} + {2'b00, row} + {2'b00, col};
  endfunction

  function automatic letter_t first_filler(letter_t ignored);
    return (ignored == CODE_Z) ? CODE_Q : CODE_Z;
  endfunction

  function automatic letter_t second_filler(letter_t ignored);
    letter_t f;
    if (ignored == CODE_Z) begin
      f = CODE_X;
    end else if (ignored == CODE_X) begin
      f = CODE_Q;
    end else begin
      f = CODE_X;
    end
    return f;
  endfunction

endpackage

/* rtl/core/playfair_digraph_cipher.sv */
// Top level of the Playfair digraph cipher block.
// Depends on plf_pkg, plf_front, plf_locate, plf_square and assert_macros.svh.
//
// Usage:
//   Requests arrive on the in_valid/in_ready channel: cmd selects clear
//   square, key letter or digraph transform. Send a clear, then the keyword
//   letters, then A to Z to complete the square; transform requests follow.
//   Every request gives exactly one result on out_valid/out_ready.
//   Configuration (ignored letter, decrypt mode) must be written through
//   cfg_we/cfg_index/cfg_data only while no request is in flight (unenforced).
// Timing:
//   Between acceptance and out_valid, the position table lookup is registered,
//   then the key square read. Throughput is one request per cycle; the
//   pipeline holds as a whole only while a result waits and out_ready is
//   low, otherwise in_ready stays high.
// Reset:
//   rst clears the pipeline valids, loads ignored letter J and encrypt mode,
//   and empties the square. The square and position memories keep their
//   contents; cells past the fill count read as letter A.
`include "assert_macros.svh"

module playfair_digraph_cipher import plf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [4:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] cmd,
  input  logic [4:0] letter_a,
  input  logic [4:0] letter_b,
  input  logic       single_letter,
  input  logic [7:0] tag_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [4:0] out_a,
  output logic [4:0] out_b,
  output logic [7:0] tag_out,
  output logic       letter_absent,
  output logic       error_seen,
  output logic [4:0] cells_filled
);

  logic    advance;
  logic    acc;
  logic    s1_valid;
  key_wr_t key_wr;
  item_t   item;
  cell_t   pos_a;
  cell_t   pos_b;
  cell_t   cell_a;
  cell_t   cell_b;

  // Advance the whole pipeline unless a finished result is held back.
  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;
  assign acc      = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= in_valid;
      out_valid <= s1_valid;
    end
  end

  plf_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .acc           (acc),
    .advance       (advance),
    .cmd           (cmd),
    .letter_a      (letter_a),
    .letter_b      (letter_b),
    .single_letter (single_letter),
    .tag_in        (tag_in),
    .key_wr        (key_wr),
    .item          (item),
    .pos_a         (pos_a),
    .pos_b         (pos_b)
  );

  plf_locate u_locate (
    .pos_a   (pos_a),
    .pos_b   (pos_b),
    .decrypt (item.decrypt),
    .cell_a  (cell_a),
    .cell_b  (cell_b)
  );

  plf_square u_square (
    .clk           (clk),
    .advance       (advance),
    .key_wr        (key_wr),
    .item          (item),
    .cell_a        (cell_a),
    .cell_b        (cell_b),
    .out_a         (out_a),
    .out_b         (out_b),
    .tag_out       (tag_out),
    .letter_absent (letter_absent),
    .error_seen    (error_seen),
    .cells_filled  (cells_filled)
  );

  `CHK_IMPLY(absent_sets_error, out_valid && letter_absent, error_seen,
             "absent letter reported without sticky error")

endmodule

/* rtl/core/plf_front.sv */
// Request stage: configuration, letter bookkeeping and position table lookup.
// Depends on plf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module plf_front import plf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [4:0] cfg_data,
  input  logic       acc,
  input  logic       advance,
  input  logic [1:0] cmd,
  input  letter_t    letter_a,
  input  letter_t    letter_b,
  input  logic       single_letter,
  input  logic [7:0] tag_in,
  output key_wr_t    key_wr,
  output item_t      item,
  output cell_t      pos_a,
  output cell_t      pos_b
);

  localparam logic [25:0] USED_RESET = 26'(1) << IGNORED_RESET;

  letter_t     ignored;
  logic        decrypt;
  logic [25:0] used;
  logic [25:0] placed;
  logic [4:0]  fill_count;
  logic        sticky;

  logic [25:0] used_next;
  logic [25:0] placed_next;
  logic [4:0]  fill_count_next;
  logic        sticky_next;

  cell_t pos_mem [LETTERS];

  letter_t     b_eff;
  letter_t     f1;
  logic        a_in;
  logic        b_in;
  logic        a_placed;
  logic        b_placed;
  logic        key_ok;
  logic        absent;
  logic [25:0] ign_mask;
  logic [25:0] a_mask;

  assign f1       = first_filler(ignored);
  assign b_eff    = single_letter ? ((letter_a == f1) ? second_filler(ignored) : f1)
                                  : letter_b;
  assign a_in     = (letter_a <= LAST_LETTER);
  assign b_in     = (b_eff <= LAST_LETTER);
  assign a_placed = a_in && placed[letter_a];
  assign b_placed = b_in && placed[b_eff];
  assign ign_mask = (ignored <= LAST_LETTER) ? (26'(1) << ignored) : '0;
  assign a_mask   = a_in ? (26'(1) << letter_a) : '0;
  assign key_ok   = (cmd == CMD_KEY) && a_in && (fill_count < CELL_COUNT) &&
                    !used[letter_a];
  assign absent   = (cmd == CMD_XFORM) && !(a_placed && b_placed);

  always_comb begin
    used_next       = used;
    placed_next     = placed;
    fill_count_next = fill_count;
    sticky_next     = sticky;
    unique case (cmd)
      CMD_CLEAR: begin
        used_next       = ign_mask;
        placed_next     = '0;
        fill_count_next = '0;
        sticky_next     = 1'b0;
      end
      CMD_KEY: begin
        if (key_ok) begin
          used_next       = used | a_mask;
          placed_next     = placed | a_mask;
          fill_count_next = fill_count + 5'd1;
        end
      end
      CMD_XFORM: begin
        if (absent) begin
          sticky_next = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ignored    <= IGNORED_RESET;
      decrypt    <= 1'b0;
      used       <= USED_RESET;
      placed     <= '0;
      fill_count <= '0;
      sticky     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_IGNORED: ignored <= cfg_data;
          CFG_DECRYPT: decrypt <= cfg_data[0];
          default: begin
          end
        endcase
      end
      if (acc) begin
        used       <= used_next;
        placed     <= placed_next;
        fill_count <= fill_count_next;
        sticky     <= sticky_next;
      end
    end
  end

  // Position table: written by key letters, read for both digraph letters.
  always_ff @(posedge clk) begin
    if (acc && key_ok) begin
      pos_mem[letter_a] <= fill_count;
    end
    if (advance) begin
      pos_a <= pos_mem[letter_a];
      pos_b <= pos_mem[b_eff];
      item  <= '{xform:   (cmd == CMD_XFORM),
                 absent:  absent,
                 ra:      letter_a,
                 rb:      b_eff,
                 tag:     tag_in,
                 sticky:  sticky_next,
                 fill:    fill_count_next,
                 decrypt: decrypt};
    end
  end

  assign key_wr = '{en: acc && key_ok, slot: fill_count, letter: letter_a};

  `CHK_ALWAYS(fill_in_range, fill_count <= CELL_COUNT, "fill count beyond square size")
  `CHK_ALWAYS(placed_in_used, (placed & ~used) == '0, "placed letter not marked used")
  `CHK_ALWAYS(placed_matches_fill, $countones(placed) == int'(fill_count),
              "placed letters disagree with fill count")

endmodule

/* rtl/core/plf_locate.sv */
// Digraph rule logic: maps two square positions to the two target cells.
// Depends on plf_pkg.
module plf_locate import plf_pkg::*; (
  input  cell_t pos_a,
  input  cell_t pos_b,
  input  logic  decrypt,
  output cell_t cell_a,
  output cell_t cell_b
);

  rc_t rc_a;
  rc_t rc_b;

  assign rc_a = split_pos(pos_a);
  assign rc_b = split_pos(pos_b);

  always_comb begin
    if (rc_a.row == rc_b.row) begin
      cell_a = cell_index(rc_a.row, step_coord(rc_a.col, decrypt));
      cell_b = cell_index(rc_b.row, step_coord(rc_b.col, decrypt));
    end else if (rc_a.col == rc_b.col) begin
      cell_a = cell_index(step_coord(rc_a.row, decrypt), rc_a.col);
      cell_b = cell_index(step_coord(rc_b.row, decrypt), rc_b.col);
    end else begin
      cell_a = cell_index(rc_a.row, rc_b.col);
      cell_b = cell_index(rc_b.row, rc_a.col);
    end
  end

endmodule

/* rtl/core/plf_square.sv */
// Key square memory and result register with the final letter select.
// Depends on plf_pkg.
module plf_square import plf_pkg::*; (
  input  logic       clk,
  input  logic       advance,
  input  key_wr_t    key_wr,
  input  item_t      item,
  input  cell_t      cell_a,
  input  cell_t      cell_b,
  output letter_t    out_a,
  output letter_t    out_b,
  output logic [7:0] tag_out,
  output logic       letter_absent,
  output logic       error_seen,
  output logic [4:0] cells_filled
);

  letter_t sq_mem [CELLS];

  item_t   res;
  letter_t q_a;
  letter_t q_b;
  logic    zero_a;
  logic    zero_b;

  always_ff @(posedge clk) begin
    if (key_wr.en) begin
      sq_mem[key_wr.slot] <= key_wr.letter;
    end
    if (advance) begin
      q_a    <= sq_mem[cell_a];
      q_b    <= sq_mem[cell_b];
      zero_a <= (cell_a >= item.fill);
      zero_b <= (cell_b >= item.fill);
      res    <= item;
    end
  end

  // Cells not yet filled since the last clear read as letter A.
  always_comb begin
    if (!res.xform) begin
      out_a = '0;
      out_b = '0;
    end else if (res.absent) begin
      out_a = res.ra;
      out_b = res.rb;
    end else begin
      out_a = zero_a ? '0 : q_a;
      out_b = zero_b ? '0 : q_b;
    end
  end

  assign tag_out       = res.tag;
  assign letter_absent = res.absent;
  assign error_seen    = res.sticky;
  assign cells_filled  = res.fill;

endmodule
